### sv/far_pkg.sv
// fraction add / multiply / reduce: shared types and constants
// no dependencies; imported by every module of the block
`default_nettype none

package far_pkg;

    localparam int OPERAND_BITS_DEF = 16;
    localparam int RES_NUM_BITS     = 33;
    localparam int RES_DEN_BITS     = 31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_ABS,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_seq_ctl;

endpackage

`default_nettype wire

### sv/far_mul.sv
// bit-serial shift-add multiplier for unsigned magnitudes, one multiplier bit per step
// depends on far_pkg (t_seq_ctl)
`default_nettype none

module far_mul import far_pkg::*; #(
    parameter int W = OPERAND_BITS_DEF
) (
    input  logic             i_clk,
    input  t_seq_ctl         i_ctl,
    input  logic [W-1:0]     i_mcand,
    input  logic [W-1:0]     i_mplier,
    output logic [2*W-1:0]   o_prod
);

    logic [W-1:0] r_mcand;
    logic [W-1:0] r_hi;
    logic [W-1:0] r_lo;
    logic [W-1:0] n_hi;
    logic [W-1:0] n_lo;
    logic [W:0]   w_sum;

    always_comb begin
        w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(W+1){1'b0}});
        n_hi  = w_sum[W:1];
        n_lo  = {w_sum[0], r_lo[W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (i_ctl.step) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

### sv/far_gcd.sv
// binary gcd, one shift or subtract-and-shift per step
// strips common factors of two first and keeps the stripped operands as dividends
// depends on far_pkg (t_seq_ctl)
`default_nettype none

module far_gcd import far_pkg::*; #(
    parameter int N = 2 * OPERAND_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_seq_ctl     i_ctl,
    input  logic [N-1:0] i_a,
    input  logic [N-1:0] i_b,
    output logic         o_done,
    output logic [N-1:0] o_gcd,
    output logic [N-1:0] o_a_red,
    output logic [N-1:0] o_b_red
);

    logic [N-1:0] r_a;
    logic [N-1:0] r_b;
    logic [N-1:0] r_a0;
    logic [N-1:0] r_b0;
    logic         r_pre;
    logic         r_done;
    logic [N:0]   w_dab;
    logic [N:0]   w_dba;
    logic         w_run;
    logic         w_any_odd;

    assign w_dab     = {1'b0, r_a} - {1'b0, r_b};
    assign w_dba     = {1'b0, r_b} - {1'b0, r_a};
    assign w_run     = i_ctl.step && !r_done;
    assign w_any_odd = r_a[0] | r_b[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_pre  <= 1'b0;
        end else if (i_ctl.load) begin
            r_done <= 1'b0;
            r_pre  <= 1'b1;
        end else if (w_run) begin
            if (r_pre) begin
                if (w_any_odd) begin
                    r_pre <= 1'b0;
                end
            end else if (r_a == r_b) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (w_run) begin
            if (r_pre) begin
                if (!w_any_odd) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                end else begin
                    r_a0 <= r_a;
                    r_b0 <= r_b;
                end
            end else if (r_a != r_b) begin
                if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (!w_dab[N]) begin
                    r_a <= w_dab[N:1];
                end else begin
                    r_b <= w_dba[N:1];
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_gcd   = r_a;
    assign o_a_red = r_a0;
    assign o_b_red = r_b0;

endmodule

`default_nettype wire

### sv/far_div.sv
// restoring divider, one quotient bit per step
// depends on far_pkg (t_seq_ctl)
`default_nettype none

module far_div import far_pkg::*; #(
    parameter int N = 2 * OPERAND_BITS_DEF
) (
    input  logic         i_clk,
    input  t_seq_ctl     i_ctl,
    input  logic [N-1:0] i_dividend,
    input  logic [N-1:0] i_divisor,
    output logic [N-1:0] o_quo
);

    logic [N-1:0] r_dvsr;
    logic [N-1:0] r_rem;
    logic [N-1:0] r_quo;
    logic [N-1:0] n_rem;
    logic [N-1:0] n_quo;
    logic [N:0]   w_trial;
    logic [N:0]   w_diff;
    logic         w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[N-1]};
        w_diff  = w_trial - {1'b0, r_dvsr};
        w_ge    = !w_diff[N];
        n_rem   = w_ge ? w_diff[N-1:0] : w_trial[N-1:0];
        n_quo   = {r_quo[N-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvsr <= i_divisor;
            r_rem  <= '0;
            r_quo  <= i_dividend;
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

### sv/fraction_add_multiply_reduce_top.sv
// fraction add / multiply with gcd reduction, top level and sequencer
// depends on far_pkg, far_mul, far_gcd, far_div
//
//   channel   direction   handshake                  payload
//   in        request     i_in_valid / o_in_ready    i_req_type, i_num_a, i_den_a,
//                                                    i_num_b, i_den_b
//   out       result      o_out_valid / i_out_ready  o_res_num, o_res_den, o_invalid
//
// one request at a time; the serial multiplies and the sum, then the binary gcd loop
// (data dependent), then the serial dividers and the output register
// a zero denominator goes straight to the output, a zero result skips gcd and dividers
// synchronous active-low reset clears the sequencer and the output valid
// a finished result waits in the sequencer while the output register is still full
`default_nettype none

module fraction_add_multiply_reduce_top import far_pkg::*; #(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic signed [OPERAND_BITS-1:0] i_num_a,
    input  logic signed [OPERAND_BITS-1:0] i_den_a,
    input  logic signed [OPERAND_BITS-1:0] i_num_b,
    input  logic signed [OPERAND_BITS-1:0] i_den_b,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [RES_NUM_BITS-1:0] o_res_num,
    output logic [RES_DEN_BITS-1:0]        o_res_den,
    output logic                           o_invalid
);

    localparam int W  = OPERAND_BITS;
    localparam int N  = 2 * W;
    localparam int CW = $clog2(N + 1);
    localparam int XW = (N + 1 > RES_NUM_BITS) ? N + 1 : RES_NUM_BITS;

    t_state  r_state;
    t_state  n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_out_valid;

    logic          r_mul;
    logic          r_inv;
    logic          r_zero;
    logic          r_neg;
    logic          r_s1;
    logic          r_s2;
    logic          r_sd;
    logic [N:0]    r_rn;
    logic signed [RES_NUM_BITS-1:0] r_res_num;
    logic [RES_DEN_BITS-1:0]        r_res_den;
    logic          r_res_inv;

    t_seq_ctl      w_mul_ctl;
    t_seq_ctl      w_gcd_ctl;
    t_seq_ctl      w_div_ctl;
    logic          w_in_ready;
    logic          w_accept;
    logic          w_out_load;
    logic          w_den_zero;

    logic [W-1:0]  w_ma;
    logic [W-1:0]  w_mb;
    logic [W-1:0]  w_mda;
    logic [W-1:0]  w_mdb;
    logic [N-1:0]  w_p1;
    logic [N-1:0]  w_p2;
    logic [N-1:0]  w_p3;
    logic [N:0]    w_x1;
    logic [N:0]    w_x2;
    logic [N:0]    w_neg_rn;
    logic [N-1:0]  w_mn;
    logic          w_gcd_done;
    logic [N-1:0]  w_gcd;
    logic [N-1:0]  w_a_red;
    logic [N-1:0]  w_b_red;
    logic [N-1:0]  w_qn;
    logic [N-1:0]  w_qd;
    logic [XW-1:0] w_qn_ext;
    logic [XW-1:0] w_qd_ext;
    logic [XW-1:0] w_sn;

    // operand magnitudes
    assign w_ma  = i_num_a[W-1] ? W'(-i_num_a) : W'(i_num_a);
    assign w_mb  = i_num_b[W-1] ? W'(-i_num_b) : W'(i_num_b);
    assign w_mda = i_den_a[W-1] ? W'(-i_den_a) : W'(i_den_a);
    assign w_mdb = i_den_b[W-1] ? W'(-i_den_b) : W'(i_den_b);

    assign w_den_zero = (i_den_a == '0) || (i_den_b == '0);
    assign w_accept   = i_in_valid && w_in_ready;

    far_mul #(.W(W)) u_mul1 (
        .i_clk    (i_clk),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (w_ma),
        .i_mplier (i_req_type ? w_mb : w_mdb),
        .o_prod   (w_p1)
    );

    far_mul #(.W(W)) u_mul2 (
        .i_clk    (i_clk),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (w_mb),
        .i_mplier (w_mda),
        .o_prod   (w_p2)
    );

    far_mul #(.W(W)) u_mul3 (
        .i_clk    (i_clk),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (w_mda),
        .i_mplier (w_mdb),
        .o_prod   (w_p3)
    );

    // signed raw numerator terms
    assign w_x1     = r_s1 ? -{1'b0, w_p1} : {1'b0, w_p1};
    assign w_x2     = r_s2 ? -{1'b0, w_p2} : {1'b0, w_p2};
    assign w_neg_rn = -r_rn;
    assign w_mn     = r_rn[N] ? w_neg_rn[N-1:0] : r_rn[N-1:0];

    far_gcd #(.N(N)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_gcd_ctl),
        .i_a     (w_mn),
        .i_b     (w_p3),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd),
        .o_a_red (w_a_red),
        .o_b_red (w_b_red)
    );

    far_div #(.N(N)) u_div_num (
        .i_clk      (i_clk),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_a_red),
        .i_divisor  (w_gcd),
        .o_quo      (w_qn)
    );

    far_div #(.N(N)) u_div_den (
        .i_clk      (i_clk),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_b_red),
        .i_divisor  (w_gcd),
        .o_quo      (w_qd)
    );

    assign w_qn_ext = {{(XW-N){1'b0}}, w_qn};
    assign w_qd_ext = {{(XW-N){1'b0}}, w_qd};
    assign w_sn     = r_neg ? -w_qn_ext : w_qn_ext;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        w_mul_ctl  = '0;
        w_gcd_ctl  = '0;
        w_div_ctl  = '0;
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (w_den_zero) begin
                        n_state = S_DONE;
                    end else begin
                        w_mul_ctl.load = 1'b1;
                        n_cnt          = '0;
                        n_state        = S_MUL;
                    end
                end
            end
            S_MUL: begin
                w_mul_ctl.step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_ABS;
            end
            S_ABS: begin
                if (r_rn == '0) begin
                    n_state = S_DONE;
                end else begin
                    w_gcd_ctl.load = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_GCD: begin
                w_gcd_ctl.step = 1'b1;
                if (w_gcd_done) begin
                    w_div_ctl.load = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                w_div_ctl.step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(N - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mul  <= i_req_type;
            r_inv  <= w_den_zero;
            r_zero <= 1'b0;
            r_s1   <= i_num_a[W-1] ^ (i_req_type ? i_num_b[W-1] : i_den_b[W-1]);
            r_s2   <= i_num_b[W-1] ^ i_den_a[W-1];
            r_sd   <= i_den_a[W-1] ^ i_den_b[W-1];
        end
        if (r_state == S_SUM) begin
            r_rn <= r_mul ? w_x1 : w_x1 + w_x2;
        end
        if (r_state == S_ABS) begin
            r_zero <= (r_rn == '0);
            r_neg  <= r_rn[N] ^ r_sd;
        end
        if (w_out_load) begin
            r_res_inv <= r_inv;
            if (r_inv) begin
                r_res_num <= '0;
                r_res_den <= '0;
            end else if (r_zero) begin
                r_res_num <= '0;
                r_res_den <= RES_DEN_BITS'(1);
            end else begin
                r_res_num <= w_sn[RES_NUM_BITS-1:0];
                r_res_den <= w_qd_ext[RES_DEN_BITS-1:0];
            end
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;
    assign o_invalid   = r_res_inv;

endmodule

`default_nettype wire
